### rtl/core/gsas_pkg.sv
// Shared types and codes for the greedy symbol alignment scorer.
// Holds the command and result item structs, operation and status codes and the FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsas_pkg;

  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_DOC     = 16;
  // An align step never reports more than this many rows.
  localparam int RES_CAP         = 32;

  localparam logic [2:0] OP_CLR_Q  = 3'd0;
  localparam logic [2:0] OP_ADD_Q  = 3'd1;
  localparam logic [2:0] OP_SORT   = 3'd2;
  localparam logic [2:0] OP_CLR_D  = 3'd3;
  localparam logic [2:0] OP_ADD_D  = 3'd4;
  localparam logic [2:0] OP_ALIGN  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNLISTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        query_symbol;
    logic [15:0]        doc_symbol;
    logic signed [31:0] path_score;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         row_index;
    logic               paired_valid;
    logic [15:0]        paired_symbol;
    logic signed [31:0] row_subscore;
    logic signed [31:0] total_score;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_D_RD,
    S_D_DAT,
    S_SORT_I,
    S_SORT_J,
    S_A_ROW,
    S_A_RD,
    S_A_DAT,
    S_A_TK,
    S_A_EMIT,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### rtl/core/gsas_sat_add.sv
// Saturating signed 32-bit adder shared by the document score update and the running total.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module gsas_sat_add (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] y
);

  logic signed [32:0] sum;

  always_comb begin
    sum = 33'(a) + 33'(b);
    if (sum > 33'sh0_7FFF_FFFF) begin
      y = 32'sh7FFF_FFFF;
    end else if (sum < -33'sh0_8000_0000) begin
      y = 32'sh8000_0000;
    end else begin
      y = sum[31:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/greedy_symbol_alignment_scorer.sv
// Top level of the greedy symbol alignment scorer: sequencer, row table and document memory.
// Depends on gsas_pkg and gsas_sat_add.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low; busy stays high until the item's
// work is done. Results appear on result for one cycle each with result_strobe high, and
// the receiver must take them then, since it has no way to stall the block. An add query
// path scans the row table one row a cycle. An add document path scans the rows, then the
// row's document list through the registered document memory read. A sort is an exchange
// sort that touches one row a cycle. Align walks each row's list, and each candidate that
// beats the row's best so far is checked against the taken symbols one per cycle; one
// result leaves per row visited. The document lists live in one memory of
// MAX_ROWS * MAX_DOC_PER_ROW entries. Sorting moves only a slot pointer per row, so lists
// never get copied.
module greedy_symbol_alignment_scorer #(
  parameter int MAX_ROWS        = gsas_pkg::DEF_MAX_ROWS,
  parameter int MAX_DOC_PER_ROW = gsas_pkg::DEF_MAX_DOC
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gsas_pkg::cmd_t   cmd,
  output logic             busy,
  output gsas_pkg::result_t result,
  output logic             result_strobe
);

  import gsas_pkg::*;

  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW   = $clog2(MAX_ROWS + 1);
  localparam int DW   = $clog2(MAX_DOC_PER_ROW + 1);
  localparam int MEMD = MAX_ROWS * MAX_DOC_PER_ROW;
  localparam int AW   = (MEMD > 1) ? $clog2(MEMD) : 1;
  localparam int TW   = $clog2(MEMD + 1);

  state_t state, state_next;

  // Latched command item.
  logic [2:0]         op;
  logic [15:0]        q_sym;
  logic [15:0]        d_sym;
  logic signed [31:0] p_score;

  // Row table. slot_a points each row at its region of the document memory.
  logic [15:0]   qsym_a [MAX_ROWS];
  logic [15:0]   pcnt_a [MAX_ROWS];
  logic [DW-1:0] dcnt_a [MAX_ROWS];
  logic [RW-1:0] slot_a [MAX_ROWS];
  logic [15:0]   taken_a [MAX_ROWS];

  logic [CW-1:0] rows_used;
  logic [TW-1:0] doc_total;
  logic [CW-1:0] taken_count;

  // Sequencer counters and working registers.
  logic [CW-1:0] i;
  logic [CW-1:0] k;
  logic [DW-1:0] j;
  logic [RW-1:0] r_idx;
  logic [RW-1:0] cur_slot;
  logic [DW-1:0] cur_cnt;
  logic [1:0]    status_r;

  // Row held during the sort's inner pass.
  logic [15:0]   rec_q;
  logic [15:0]   rec_p;
  logic [DW-1:0] rec_d;
  logic [RW-1:0] rec_s;

  // Align bookkeeping.
  logic signed [31:0] best;
  logic [15:0]        bsym;
  logic               got;
  logic signed [31:0] total;

  // Document memory.
  logic [15:0]        sym_mem   [MEMD];
  logic signed [31:0] score_mem [MEMD];
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [15:0]        mem_wsym;
  logic signed [31:0] mem_wscore;
  logic [15:0]        rd_sym;
  logic signed [31:0] rd_score;

  logic signed [31:0] sat_a, sat_b, sat_y;

  result_t result_next;
  logic    strobe_next;

  logic [RW-1:0] i_idx, k_idx, ru_idx, tc_idx;
  logic [CW:0]   i_inc;
  logic [CW:0]   tc_inc;
  logic          emit_stop, emit_last;
  logic          q_hit, scan_end, list_end, tk_end, tk_hit;

  assign i_idx  = i[RW-1:0];
  assign k_idx  = k[RW-1:0];
  assign ru_idx = rows_used[RW-1:0];
  assign tc_idx = taken_count[RW-1:0];

  assign mem_addr = AW'(cur_slot) * AW'(MAX_DOC_PER_ROW) + AW'(j);

  assign scan_end = (k >= rows_used);
  assign q_hit    = !scan_end && (qsym_a[k_idx] == q_sym);
  assign list_end = (j >= cur_cnt);
  assign tk_end   = (k >= taken_count);
  assign tk_hit   = !tk_end && (taken_a[k_idx] == rd_sym);

  // Align end-of-row decision: stop once the taken count reaches the number of listed
  // document entries, or when the rows or the result budget run out.
  assign i_inc     = (CW + 1)'(i) + (CW + 1)'(1);
  assign tc_inc    = (CW + 1)'(taken_count) + (CW + 1)'(got);
  assign emit_stop = got && (32'(tc_inc) >= 32'(doc_total));
  assign emit_last = emit_stop || (i_inc >= (CW + 1)'(rows_used)) ||
                     (32'(i_inc) >= 32'(RES_CAP));

  gsas_sat_add u_sat (
    .a(sat_a),
    .b(sat_b),
    .y(sat_y)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= strobe_next;
    end
    result <= result_next;
  end

  // Document memory: one write port, one registered read port on the same address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sym_mem[mem_addr]   <= mem_wsym;
      score_mem[mem_addr] <= mem_wscore;
    end
    rd_sym   <= sym_mem[mem_addr];
    rd_score <= score_mem[mem_addr];
  end

  always_comb begin
    state_next  = state;
    result_next = '0;
    strobe_next = 1'b0;
    mem_we      = 1'b0;
    mem_wsym    = d_sym;
    mem_wscore  = p_score;
    sat_a       = total;
    sat_b       = best;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.operation) inside
            OP_ADD_Q, OP_ADD_D: state_next = S_FIND;
            OP_SORT:            state_next = S_SORT_I;
            OP_ALIGN:           state_next = S_A_ROW;
            default:            state_next = S_RESP;
          endcase
        end
      end
      S_FIND: begin
        if (scan_end) begin
          state_next = S_RESP;
        end else if (q_hit) begin
          state_next = (op == OP_ADD_Q) ? S_RESP : S_D_RD;
        end
      end
      S_D_RD: begin
        if (list_end) begin
          mem_we     = (32'(cur_cnt) < MAX_DOC_PER_ROW);
          state_next = S_RESP;
        end else begin
          state_next = S_D_DAT;
        end
      end
      S_D_DAT: begin
        sat_a = rd_score;
        sat_b = p_score;
        if (rd_sym == d_sym) begin
          mem_we     = 1'b1;
          mem_wscore = sat_y;
          state_next = S_RESP;
        end else begin
          state_next = S_D_RD;
        end
      end
      S_SORT_I: begin
        state_next = (i >= rows_used) ? S_RESP : S_SORT_J;
      end
      S_SORT_J: begin
        if (scan_end) begin
          state_next = S_SORT_I;
        end
      end
      S_A_ROW: begin
        if (i >= rows_used) begin
          strobe_next      = 1'b1;
          result_next.last = 1'b1;
          state_next       = S_IDLE;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        state_next = list_end ? S_A_EMIT : S_A_DAT;
      end
      S_A_DAT: begin
        state_next = (rd_score > best) ? S_A_TK : S_A_RD;
      end
      S_A_TK: begin
        if (tk_end || tk_hit) begin
          state_next = S_A_RD;
        end
      end
      S_A_EMIT: begin
        strobe_next               = 1'b1;
        result_next.status        = ST_OK;
        result_next.row_index     = 5'(i);
        result_next.paired_valid  = got;
        result_next.paired_symbol = bsym;
        result_next.row_subscore  = got ? best : '0;
        result_next.total_score   = got ? sat_y : total;
        result_next.last          = emit_last;
        state_next                = emit_last ? S_IDLE : S_A_ROW;
      end
      S_RESP: begin
        strobe_next        = 1'b1;
        result_next.status = status_r;
        result_next.last   = 1'b1;
        state_next         = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used   <= '0;
      doc_total   <= '0;
      taken_count <= '0;
      for (int n = 0; n < MAX_ROWS; n++) begin
        dcnt_a[n] <= '0;
        slot_a[n] <= RW'(n);
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op       <= cmd.operation;
            q_sym    <= cmd.query_symbol;
            d_sym    <= cmd.doc_symbol;
            p_score  <= cmd.path_score;
            k        <= '0;
            i        <= '0;
            total    <= '0;
            status_r <= ST_OK;
            case (cmd.operation)
              OP_CLR_Q: begin
                rows_used <= '0;
                doc_total <= '0;
                for (int n = 0; n < MAX_ROWS; n++) begin
                  dcnt_a[n] <= '0;
                end
              end
              OP_CLR_D: begin
                doc_total <= '0;
                for (int n = 0; n < MAX_ROWS; n++) begin
                  dcnt_a[n] <= '0;
                end
              end
              OP_ALIGN: taken_count <= '0;
              default: ;
            endcase
          end
        end
        S_FIND: begin
          if (scan_end) begin
            if (op == OP_ADD_Q) begin
              if (32'(rows_used) < MAX_ROWS) begin
                qsym_a[ru_idx] <= q_sym;
                pcnt_a[ru_idx] <= 16'd1;
                dcnt_a[ru_idx] <= '0;
                rows_used      <= rows_used + CW'(1);
              end else begin
                status_r <= ST_FULL;
              end
            end else begin
              status_r <= ST_UNLISTED;
            end
          end else if (q_hit) begin
            r_idx    <= k_idx;
            cur_slot <= slot_a[k_idx];
            cur_cnt  <= dcnt_a[k_idx];
            j        <= '0;
            if (op == OP_ADD_Q && pcnt_a[k_idx] != 16'hFFFF) begin
              pcnt_a[k_idx] <= pcnt_a[k_idx] + 16'd1;
            end
          end else begin
            k <= k + CW'(1);
          end
        end
        S_D_RD: begin
          if (list_end) begin
            if (32'(cur_cnt) < MAX_DOC_PER_ROW) begin
              dcnt_a[r_idx] <= cur_cnt + DW'(1);
              doc_total     <= doc_total + TW'(1);
            end else begin
              status_r <= ST_FULL;
            end
          end
        end
        S_D_DAT: begin
          if (rd_sym != d_sym) begin
            j <= j + DW'(1);
          end
        end
        S_SORT_I: begin
          if (i < rows_used) begin
            rec_q <= qsym_a[i_idx];
            rec_p <= pcnt_a[i_idx];
            rec_d <= dcnt_a[i_idx];
            rec_s <= slot_a[i_idx];
            k     <= i + CW'(1);
          end
        end
        S_SORT_J: begin
          if (scan_end) begin
            qsym_a[i_idx] <= rec_q;
            pcnt_a[i_idx] <= rec_p;
            dcnt_a[i_idx] <= rec_d;
            slot_a[i_idx] <= rec_s;
            i             <= i + CW'(1);
          end else begin
            if (rec_p < pcnt_a[k_idx]) begin
              qsym_a[k_idx] <= rec_q;
              pcnt_a[k_idx] <= rec_p;
              dcnt_a[k_idx] <= rec_d;
              slot_a[k_idx] <= rec_s;
              rec_q         <= qsym_a[k_idx];
              rec_p         <= pcnt_a[k_idx];
              rec_d         <= dcnt_a[k_idx];
              rec_s         <= slot_a[k_idx];
            end
            k <= k + CW'(1);
          end
        end
        S_A_ROW: begin
          if (i < rows_used) begin
            cur_slot <= slot_a[i_idx];
            cur_cnt  <= dcnt_a[i_idx];
          end
          j    <= '0;
          best <= '0;
          got  <= 1'b0;
          bsym <= '0;
        end
        S_A_RD: ;
        S_A_DAT: begin
          if (rd_score > best) begin
            k <= '0;
          end else begin
            j <= j + DW'(1);
          end
        end
        S_A_TK: begin
          if (tk_end) begin
            best <= rd_score;
            bsym <= rd_sym;
            got  <= 1'b1;
            j    <= j + DW'(1);
          end else if (tk_hit) begin
            j <= j + DW'(1);
          end else begin
            k <= k + CW'(1);
          end
        end
        S_A_EMIT: begin
          if (got) begin
            taken_a[tc_idx] <= bsym;
            taken_count     <= taken_count + CW'(1);
            total           <= sat_y;
          end
          i <= i + CW'(1);
        end
        S_RESP: ;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/gsas_checker.sv
// Port-level checks for the greedy symbol alignment scorer, bound to its top level.
// Depends on gsas_pkg and greedy_symbol_alignment_scorer.
`timescale 1ns / 1ps
`default_nettype none

module gsas_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input gsas_pkg::cmd_t    cmd,
  input logic              busy,
  input gsas_pkg::result_t result,
  input logic              result_strobe
);

  import gsas_pkg::*;

  // Every accepted item raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // An item that is not finished keeps the block busy.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last |-> busy)
    else $error("non-final result while idle");

  // Error results end their item.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.status != ST_OK |-> result.last)
    else $error("error result not final");

  // An unpaired row carries no subscore.
  a_unpaired: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.paired_valid |-> result.row_subscore == 0)
    else $error("unpaired row with subscore");

  // Going idle coincides with the final result of the item.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_strobe && result.last)
    else $error("idle without final result");

endmodule

bind greedy_symbol_alignment_scorer gsas_checker u_gsas_checker (.*);

`default_nettype wire
